[rtl/adft_pkg.sv]
// shared types and status codes for the allocation double-free tracker
package adft_pkg;

    localparam logic [2:0] ST_NEW          = 3'd0;
    localparam logic [2:0] ST_REALLOC      = 3'd1;
    localparam logic [2:0] ST_DOUBLE_ALLOC = 3'd2;
    localparam logic [2:0] ST_FULL         = 3'd3;
    localparam logic [2:0] ST_FREE_OK      = 3'd4;
    localparam logic [2:0] ST_DOUBLE_FREE  = 3'd5;
    localparam logic [2:0] ST_UNKNOWN      = 3'd6;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // event token that walks down the cell chain
    typedef struct packed {
        logic       valid;
        logic       kind;
        logic       done;
        logic [2:0] status;
    } token_t;

endpackage

[rtl/adft_cell.sv]
// one table cell: holds one entry and resolves passing events against it
module adft_cell
    import adft_pkg::*;
#(
    parameter int ADDR_BITS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  token_t               tok_in,
    input  logic [ADDR_BITS-1:0] addr_in,
    output token_t               tok_out,
    output logic [ADDR_BITS-1:0] addr_out
);

    logic                 used_reg;
    logic                 used_next;
    logic                 live_reg;
    logic                 live_next;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] addr_next;
    token_t               tok_reg;
    token_t               tok_next;
    logic [ADDR_BITS-1:0] pass_reg;
    logic                 hit;
    logic                 active;

    assign hit    = used_reg && (addr_reg == addr_in);
    assign active = tok_in.valid && !tok_in.done;

    always_comb
    begin
        used_next = used_reg;
        live_next = live_reg;
        addr_next = addr_reg;
        tok_next  = tok_in;
        if (active)
        begin
            priority if (hit)
            begin
                tok_next.done = 1'b1;
                if (tok_in.kind == KIND_ALLOC)
                begin
                    if (live_reg)
                    begin
                        tok_next.status = ST_DOUBLE_ALLOC;
                    end
                    else
                    begin
                        live_next       = 1'b1;
                        tok_next.status = ST_REALLOC;
                    end
                end
                else
                begin
                    if (live_reg)
                    begin
                        live_next       = 1'b0;
                        tok_next.status = ST_FREE_OK;
                    end
                    else
                    begin
                        tok_next.status = ST_DOUBLE_FREE;
                    end
                end
            end
            else if (!used_reg)
            begin
                // first empty cell: no entry beyond it is in use
                tok_next.done = 1'b1;
                if (tok_in.kind == KIND_ALLOC)
                begin
                    used_next       = 1'b1;
                    live_next       = 1'b1;
                    addr_next       = addr_in;
                    tok_next.status = ST_NEW;
                end
                else
                begin
                    tok_next.status = ST_UNKNOWN;
                end
            end
            else
            begin
                tok_next = tok_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else if (advance)
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            live_reg <= live_next;
            addr_reg <= addr_next;
            pass_reg <= addr_in;
        end
    end

    assign tok_out  = tok_reg;
    assign addr_out = pass_reg;

    a_used_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg |=> used_reg)
        else $error("table cell lost its entry");

    a_unresolved_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        tok_reg.valid && !tok_reg.done |-> used_reg)
        else $error("event passed an empty cell unresolved");

    a_unresolved_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        tok_reg.valid && !tok_reg.done |-> pass_reg != addr_reg)
        else $error("event passed a matching cell unresolved");

endmodule

[rtl/allocation_double_free_tracker.sv]
// top level of the allocation double-free tracker: a chain of table cells
//
// input channel: in_valid/in_stall carry one event (kind, address); kind 0 is
// an allocation, kind 1 a free. output channel: out_valid/out_stall carry one
// status per event, in event order.
// each event walks the chain of ENTRIES cells, one cell per cycle unless the
// chain holds; the cell holding its address, or the first empty cell, resolves
// it. entries fill in order, so an event that finds an empty cell has already
// passed every entry. out_valid rises once the event has passed through the
// register of every cell; the status comes from the register of the last cell.
// throughput: one event per cycle unless the chain holds; the chain is a
// pipeline, so back to back events see each other's updates in order.
// an event that leaves the last cell unresolved reports table full
// (allocation) or unknown (free).
// reset empties the table and flushes the chain; no clearing pass is needed.
// when the receiver stalls a waiting result, the whole chain holds and
// in_stall rises until the result is taken.
module allocation_double_free_tracker
    import adft_pkg::*;
#(
    parameter int ENTRIES   = 64,
    parameter int ADDR_BITS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [ADDR_BITS-1:0] address,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status
);

    token_t               tok  [0:ENTRIES];
    logic [ADDR_BITS-1:0] addr [0:ENTRIES];
    logic                 advance;
    token_t               last;

    assign last    = tok[ENTRIES];
    assign advance = !last.valid || !out_stall;

    always_comb
    begin
        tok[0].valid  = in_valid;
        tok[0].kind   = kind;
        tok[0].done   = 1'b0;
        tok[0].status = ST_NEW;
    end
    assign addr[0] = address;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            adft_cell #(
                .ADDR_BITS (ADDR_BITS)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .tok_in   (tok[g]),
                .addr_in  (addr[g]),
                .tok_out  (tok[g+1]),
                .addr_out (addr[g+1])
            );
        end
    endgenerate

    assign in_stall  = !advance;
    assign out_valid = last.valid;

    always_comb
    begin
        if (last.done)
        begin
            status = last.status;
        end
        else if (last.kind == KIND_ALLOC)
        begin
            status = ST_FULL;
        end
        else
        begin
            status = ST_UNKNOWN;
        end
    end

endmodule

[bench/adft_status_checker.sv]
// checker for the allocation double-free tracker: predicts each status and compares it
module adft_status_checker
    import adft_pkg::*;
#(
    parameter int ENTRIES   = 64,
    parameter int ADDR_BITS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 kind,
    input  logic [ADDR_BITS-1:0] address,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [2:0]           status,
    output int                   mismatches,
    output int                   waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ADDR_BITS-1:0] tbl_addr [ENTRIES];
    logic                 tbl_live [ENTRIES];
    int                   used;
    logic [2:0]           expected_status_q [$];

    // table lookup and update for one event, in arrival order
    function automatic logic [2:0] resolve_event(input logic k, input logic [ADDR_BITS-1:0] a);
        int         hit;
        logic [2:0] st;
        hit = -1;
        for (int i = 0; i < used; i++)
        begin
            if (hit < 0 && tbl_addr[i] == a)
                hit = i;
        end
        if (k == KIND_ALLOC)
        begin
            if (hit >= 0)
            begin
                if (tbl_live[hit])
                    st = ST_DOUBLE_ALLOC;
                else
                begin
                    tbl_live[hit] = 1'b1;
                    st = ST_REALLOC;
                end
            end
            else if (used >= ENTRIES)
                st = ST_FULL;
            else
            begin
                tbl_addr[used] = a;
                tbl_live[used] = 1'b1;
                used++;
                st = ST_NEW;
            end
        end
        else
        begin
            if (hit < 0)
                st = ST_UNKNOWN;
            else if (tbl_live[hit])
            begin
                tbl_live[hit] = 1'b0;
                st = ST_FREE_OK;
            end
            else
                st = ST_DOUBLE_FREE;
        end
        return st;
    endfunction

    task automatic note_mismatch(input string what, input logic [2:0] exp_st,
                                 input logic [2:0] act_st);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected status %0d, got %0d", $realtime, what, exp_st, act_st);
    endtask

    initial
    begin
        mismatches = 0;
        waiting = 0;
        used = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [2:0] exp_st;
        logic [2:0] pred_st;
        if (!rst_n)
        begin
            used = 0;
            expected_status_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_status_q.size() == 0)
                    note_mismatch("status transfer with nothing pending", 3'bx, status);
                else
                begin
                    exp_st = expected_status_q.pop_front();
                    if (status !== exp_st)
                        note_mismatch("status mismatch", exp_st, status);
                end
            end
            if (in_valid && !in_stall)
            begin
                pred_st = resolve_event(kind, address);
                expected_status_q = {expected_status_q, pred_st};
            end
        end
        waiting = expected_status_q.size();
    end

endmodule

[bench/allocation_double_free_tracker_test.sv]
// testbench top for the allocation double-free tracker: stimulus, stall control and verdict
module allocation_double_free_tracker_test
    import adft_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES   = 64;
    localparam int ADDR_BITS = 64;
    localparam int POOL_SIZE = 80;
    localparam int LONG_HOLD = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 kind = KIND_ALLOC;
    logic [ADDR_BITS-1:0] address = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           status;

    int mismatches;
    int waiting;
    int idle_pct = 0;
    int stall_pct = 0;
    logic long_hold = 1'b0;
    int held = 0;

    logic [ADDR_BITS-1:0] addr_pool [POOL_SIZE];

    allocation_double_free_tracker #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .address   (address),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status)
    );

    adft_status_checker #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .address    (address),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver side: one long hold-off once requested, random stalls otherwise
    always @(negedge clk)
    begin
        if (long_hold && held < LONG_HOLD)
        begin
            out_stall <= 1'b1;
            held <= held + 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_event(input logic k, input logic [ADDR_BITS-1:0] a);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        address <= a;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // mostly pool addresses so the table fills and entries cycle live/freed
    task automatic run_random(input int count);
        int                   pick;
        int                   sel;
        logic [ADDR_BITS-1:0] a;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            sel = $urandom_range(POOL_SIZE - 1);
            if (pick < 85)
                a = addr_pool[sel];
            else if (pick < 95)
                a = {$urandom, $urandom};
            else
                a = addr_pool[sel] ^ (64'd1 << $urandom_range(ADDR_BITS - 1));
            send_event(1'($urandom_range(1)), a);
        end
    endtask

    initial
    begin
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        addr_pool[2] = 64'h8000_0000_0000_0000;
        addr_pool[3] = 64'h7fff_ffff_ffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++)
            addr_pool[i] = {$urandom, $urandom};

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every status but table full, extremes of the address
        send_event(KIND_ALLOC, '0);
        send_event(KIND_ALLOC, '1);
        send_event(KIND_ALLOC, '0);
        send_event(KIND_FREE, '0);
        send_event(KIND_FREE, '0);
        send_event(KIND_ALLOC, '0);
        send_event(KIND_FREE, 64'h5555_5555_5555_5555);
        send_event(KIND_ALLOC, 64'h8000_0000_0000_0000);
        send_event(KIND_FREE, 64'h0000_0000_0000_0001);
        send_event(KIND_FREE, '1);
        send_event(KIND_ALLOC, 64'h7fff_ffff_ffff_ffff);
        send_event(KIND_FREE, 64'h7fff_ffff_ffff_ffff);
        send_event(KIND_ALLOC, 64'haaaa_aaaa_aaaa_aaaa);

        // no idling, with one long receiver hold-off so the chain backs up
        long_hold = 1'b1;
        run_random(335);
        idle_pct = 87;
        stall_pct = 0;
        run_random(335);
        idle_pct = 0;
        stall_pct = 87;
        run_random(335);
        idle_pct = 36;
        stall_pct = 36;
        run_random(335);
        in_valid <= 1'b0;

        while (waiting != 0)
            @(posedge clk);
        repeat (ENTRIES + 16) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
